FILE: design/msp_pkg.sv
// Shared types, constants and the status length table for the MIDI stream parser.
package msp_pkg;

    localparam logic [7:0] STATUS_BIT  = 8'h80;
    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [7:0] LOW_NIBBLE  = 8'h0F;

    // Result kinds
    localparam logic [1:0] KIND_SHORT   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // Data byte counts
    localparam logic [1:0] LEN_ZERO = 2'd0;
    localparam logic [1:0] LEN_ONE  = 2'd1;
    localparam logic [1:0] LEN_TWO  = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] msg_status;
        logic [7:0] data_first;
        logic [7:0] data_second;
        logic [1:0] data_count;
        logic [1:0] kind;
        logic       last;
    } t_out_beat;

    // Parser state carried from byte to byte
    typedef struct packed {
        logic [7:0] running_status;
        logic [1:0] bytes_taken;
        logic [7:0] held_data;
        logic       in_sysex;
    } t_state;

    // Number of data bytes that follow a status byte
    function automatic logic [1:0] data_len(input logic [7:0] s);
        logic [1:0] len;
        len = LEN_ZERO;
        if (s[7]) begin
            if (s < SYSEX_START) begin
                case (s[6:4])
                    3'd4, 3'd5: len = LEN_ONE;
                    3'd7:       len = LEN_ZERO;
                    default:    len = LEN_TWO;
                endcase
            end else begin
                case (s & LOW_NIBBLE)
                    8'h01, 8'h03: len = LEN_ONE;
                    8'h02:        len = LEN_TWO;
                    default:      len = LEN_ZERO;
                endcase
            end
        end
        return len;
    endfunction

endpackage

FILE: design/msp_stream_if.sv
// Valid/ready stream interface with a typed payload.
interface msp_stream_if #(
    parameter type t_data = logic [7:0]
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/msp_step.sv
// Per-byte parser step: next state and the optional result for one byte.
module msp_step (
    input  msp_pkg::t_state    i_state,
    input  logic [7:0]         i_byte,
    output msp_pkg::t_state    o_state,
    output logic               o_emit,
    output msp_pkg::t_out_beat o_beat
);

    logic [1:0] cur_len;
    logic [1:0] new_len;

    assign cur_len = msp_pkg::data_len(i_state.running_status);
    assign new_len = msp_pkg::data_len(i_byte);

    // Decode one byte against the current state
    always_comb begin
        o_state            = i_state;
        o_emit             = 1'b0;
        o_beat.msg_status  = i_state.running_status;
        o_beat.data_first  = 8'h00;
        o_beat.data_second = 8'h00;
        o_beat.data_count  = msp_pkg::LEN_ZERO;
        o_beat.kind        = msp_pkg::KIND_SHORT;
        o_beat.last        = 1'b1;

        if (i_state.in_sysex) begin
            // Inside sysex: payload until the end byte
            o_emit            = 1'b1;
            o_beat.msg_status = msp_pkg::SYSEX_START;
            if (i_byte == msp_pkg::SYSEX_END) begin
                o_state.in_sysex = 1'b0;
                o_beat.kind      = msp_pkg::KIND_END;
            end else begin
                o_beat.data_first = i_byte;
                o_beat.kind       = msp_pkg::KIND_PAYLOAD;
                o_beat.last       = 1'b0;
            end
        end else if (i_state.bytes_taken != 2'd0) begin
            // Message in progress: any byte is data
            if (i_state.bytes_taken == 2'd1 && cur_len == msp_pkg::LEN_TWO) begin
                o_state.held_data   = i_byte;
                o_state.bytes_taken = 2'd2;
            end else begin
                o_state.bytes_taken = 2'd0;
                o_emit              = 1'b1;
                if (cur_len == msp_pkg::LEN_TWO) begin
                    o_beat.data_first  = i_state.held_data;
                    o_beat.data_second = i_byte;
                    o_beat.data_count  = msp_pkg::LEN_TWO;
                end else begin
                    o_beat.data_first = i_byte;
                    o_beat.data_count = msp_pkg::LEN_ONE;
                end
            end
        end else if (i_byte[7]) begin
            // New status byte
            o_state.running_status = i_byte;
            o_beat.msg_status      = i_byte;
            if (i_byte == msp_pkg::SYSEX_START) begin
                o_state.in_sysex = 1'b1;
            end else if (new_len == msp_pkg::LEN_ZERO) begin
                o_emit = 1'b1;
            end else begin
                o_state.bytes_taken = 2'd1;
            end
        end else if (i_state.running_status == msp_pkg::SYSEX_START) begin
            // Data after a finished sysex opens a new one
            o_state.in_sysex  = 1'b1;
            o_emit            = 1'b1;
            o_beat.data_first = i_byte;
            o_beat.kind       = msp_pkg::KIND_PAYLOAD;
            o_beat.last       = 1'b0;
        end else if (cur_len == msp_pkg::LEN_ONE) begin
            // Running status, single data byte
            o_emit            = 1'b1;
            o_beat.data_first = i_byte;
            o_beat.data_count = msp_pkg::LEN_ONE;
        end else if (cur_len == msp_pkg::LEN_TWO) begin
            o_state.held_data   = i_byte;
            o_state.bytes_taken = 2'd2;
        end
        // no status or zero-length status: byte dropped
    end

endmodule

FILE: design/midi_stream_parser_top.sv
// Top level of the MIDI byte-stream parser with running status.
//
//  channel  | dir | payload                                          | handshake
//  i_rx     | in  | rx_byte                                          | valid/ready
//  o_msg    | out | msg_status data_first data_second data_count    | valid/ready
//           |     | kind last                                        |
//
// One byte per cycle sustained while the output is not stalled: each byte
// passes an input register, the combinational step logic and the result register.
// Parser state updates as a byte leaves the input register, so the next
// byte sees it once in the input register. A stalled result holds the
// input register; bytes with no result still advance while the output is
// free or taken. Reset (synchronous, active low) clears valids and parser state.
module midi_stream_parser_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    msp_stream_if.sink   i_rx,
    msp_stream_if.source o_msg
);

    logic               r_s1_valid;
    logic [7:0]         r_s1_byte;
    msp_pkg::t_state    r_state;
    msp_pkg::t_state    n_state;
    logic               r_out_valid;
    msp_pkg::t_out_beat r_out_beat;
    msp_pkg::t_out_beat n_out_beat;
    logic               n_emit;
    logic               adv;

    // Stage 1 moves on whenever the result slot is free or being taken
    assign adv        = !r_out_valid || o_msg.ready;
    assign i_rx.ready = !r_s1_valid || adv;

    msp_step u_step (
        .i_state (r_state),
        .i_byte  (r_s1_byte),
        .o_state (n_state),
        .o_emit  (n_emit),
        .o_beat  (n_out_beat)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_s1_valid <= i_rx.valid;
        end
        if (i_rx.ready && i_rx.valid) begin
            r_s1_byte <= i_rx.data.rx_byte;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (r_s1_valid && adv) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid && n_emit;
        end
        if (adv && r_s1_valid && n_emit) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_msg.valid = r_out_valid;
    assign o_msg.data  = r_out_beat;

    // Sysex only runs under the sysex status
    a_sysex_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.in_sysex |-> r_state.running_status == msp_pkg::SYSEX_START)
        else $error("in sysex without sysex status");

    // Sysex and a pending short message never overlap
    a_sysex_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.in_sysex |-> r_state.bytes_taken == 2'd0)
        else $error("sysex while short message pending");

    // A pending message always has a real status and a legal count
    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_taken != 2'd0 |->
            r_state.running_status[7] && r_state.bytes_taken != 2'd3)
        else $error("bad pending message state");

    // Sysex results carry the sysex status; payload is never last
    a_sysex_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_beat.kind != msp_pkg::KIND_SHORT |->
            r_out_beat.msg_status == msp_pkg::SYSEX_START &&
            (r_out_beat.kind == msp_pkg::KIND_END) == r_out_beat.last)
        else $error("malformed sysex result");

    // A byte held in stage 1 under a stall is not lost
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !adv |=> r_s1_valid && $stable(r_s1_byte))
        else $error("stage 1 byte lost under stall");

endmodule

FILE: tb/sv/midi_stream_parser_top_tb.sv
// Self-checking testbench for the MIDI stream parser: directed, random and backpressure tests.
`timescale 1ns / 1ps

module midi_stream_parser_top_tb;

    logic i_clk;
    logic i_rst_n;

    msp_stream_if #(.t_data(msp_pkg::t_in_beat))  rx_if ();
    msp_stream_if #(.t_data(msp_pkg::t_out_beat)) msg_if ();

    midi_stream_parser_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_msg   (msg_if)
    );

    // Parser state mirror and the messages it says are still owed
    msp_pkg::t_state    parse_st;
    msp_pkg::t_out_beat expected_msgs[$];

    int  mismatch_count;
    int  bytes_offered;
    int  stall_left;
    bit  tx_idle_on;
    bit  rx_idle_on;
    logic [7:0] gen_status;

    // 4 ns clock
    always #2 i_clk = ~i_clk;

    // Data bytes that follow a status byte
    function automatic logic [1:0] status_data_bytes(input logic [7:0] s);
        if (!s[7])
            return msp_pkg::LEN_ZERO;
        if (s < msp_pkg::SYSEX_START) begin
            case (s[7:4])
                4'hC, 4'hD: return msp_pkg::LEN_ONE;
                default:    return msp_pkg::LEN_TWO;
            endcase
        end
        case (s[3:0])
            4'h1, 4'h3: return msp_pkg::LEN_ONE;
            4'h2:       return msp_pkg::LEN_TWO;
            default:    return msp_pkg::LEN_ZERO;
        endcase
    endfunction

    function automatic msp_pkg::t_out_beat make_msg(
        input logic [7:0] st, input logic [7:0] d1, input logic [7:0] d2,
        input logic [1:0] cnt, input logic [1:0] k, input logic lst);
        msp_pkg::t_out_beat m;
        m.msg_status  = st;
        m.data_first  = d1;
        m.data_second = d2;
        m.data_count  = cnt;
        m.kind        = k;
        m.last        = lst;
        return m;
    endfunction

    // Advance the parser mirror by one byte; returns 1 when a message comes out
    function automatic bit parse_midi_byte(input logic [7:0] b,
                                           output msp_pkg::t_out_beat m);
        logic [1:0] len;
        m = '0;
        if (parse_st.in_sysex) begin
            if (b == msp_pkg::SYSEX_END) begin
                parse_st.in_sysex = 1'b0;
                m = make_msg(msp_pkg::SYSEX_START, 8'h00, 8'h00, msp_pkg::LEN_ZERO,
                             msp_pkg::KIND_END, 1'b1);
            end else begin
                m = make_msg(msp_pkg::SYSEX_START, b, 8'h00, msp_pkg::LEN_ZERO,
                             msp_pkg::KIND_PAYLOAD, 1'b0);
            end
            return 1'b1;
        end
        // short message still waiting for data: anything counts as data
        if (parse_st.bytes_taken != 2'd0) begin
            len = status_data_bytes(parse_st.running_status);
            if (parse_st.bytes_taken == 2'd1 && len == msp_pkg::LEN_TWO) begin
                parse_st.held_data   = b;
                parse_st.bytes_taken = 2'd2;
                return 1'b0;
            end
            parse_st.bytes_taken = 2'd0;
            if (len == msp_pkg::LEN_TWO)
                m = make_msg(parse_st.running_status, parse_st.held_data, b,
                             msp_pkg::LEN_TWO, msp_pkg::KIND_SHORT, 1'b1);
            else
                m = make_msg(parse_st.running_status, b, 8'h00,
                             msp_pkg::LEN_ONE, msp_pkg::KIND_SHORT, 1'b1);
            return 1'b1;
        end
        // new status byte
        if (b[7]) begin
            parse_st.running_status = b;
            if (b == msp_pkg::SYSEX_START) begin
                parse_st.in_sysex = 1'b1;
                return 1'b0;
            end
            if (status_data_bytes(b) == msp_pkg::LEN_ZERO) begin
                m = make_msg(b, 8'h00, 8'h00, msp_pkg::LEN_ZERO, msp_pkg::KIND_SHORT, 1'b1);
                return 1'b1;
            end
            parse_st.bytes_taken = 2'd1;
            return 1'b0;
        end
        // data byte between messages: running status applies
        if (parse_st.running_status == 8'h00)
            return 1'b0;
        if (parse_st.running_status == msp_pkg::SYSEX_START) begin
            parse_st.in_sysex = 1'b1;
            m = make_msg(msp_pkg::SYSEX_START, b, 8'h00, msp_pkg::LEN_ZERO,
                         msp_pkg::KIND_PAYLOAD, 1'b0);
            return 1'b1;
        end
        len = status_data_bytes(parse_st.running_status);
        if (len == msp_pkg::LEN_ZERO)
            return 1'b0;
        if (len == msp_pkg::LEN_ONE) begin
            m = make_msg(parse_st.running_status, b, 8'h00, msp_pkg::LEN_ONE,
                         msp_pkg::KIND_SHORT, 1'b1);
            return 1'b1;
        end
        parse_st.held_data   = b;
        parse_st.bytes_taken = 2'd2;
        return 1'b0;
    endfunction

    task automatic report_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Check each result beat, then predict from each accepted input beat
    always @(posedge i_clk) begin
        msp_pkg::t_out_beat got;
        msp_pkg::t_out_beat want;
        if (i_rst_n) begin
            if (msg_if.valid && msg_if.ready) begin
                got = msg_if.data;
                if (expected_msgs.size() == 0) begin
                    report_error($sformatf(
                        "unexpected msg st=%h d1=%h d2=%h cnt=%0d k=%0d l=%0d",
                        got.msg_status, got.data_first, got.data_second,
                        got.data_count, got.kind, got.last));
                end else begin
                    want = expected_msgs.pop_front();
                    if (got.msg_status !== want.msg_status || got.data_first !== want.data_first
                        || got.data_second !== want.data_second
                        || got.data_count !== want.data_count || got.kind !== want.kind
                        || got.last !== want.last)
                        report_error({
                            $sformatf("exp st=%h d1=%h d2=%h cnt=%0d k=%0d l=%0d, ",
                                      want.msg_status, want.data_first, want.data_second,
                                      want.data_count, want.kind, want.last),
                            $sformatf("got st=%h d1=%h d2=%h cnt=%0d k=%0d l=%0d",
                                      got.msg_status, got.data_first, got.data_second,
                                      got.data_count, got.kind, got.last)});
                end
            end
            if (rx_if.valid && rx_if.ready) begin
                if (parse_midi_byte(rx_if.data.rx_byte, want))
                    expected_msgs.insert(expected_msgs.size(), want);
            end
        end
    end

    // Result side ready: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            msg_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            msg_if.ready <= !(rx_idle_on && $urandom_range(0, 99) < 30);
        end
    end

    // Offer one byte, optionally after a random idle gap; returns after the accepting edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (tx_idle_on)
            while ($urandom_range(0, 99) < 30)
                gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_if.valid        <= 1'b1;
        rx_if.data.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        bytes_offered++;
    endtask

    function automatic logic [7:0] rand_data();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic send_sysex();
        int n;
        n = $urandom_range(0, 6);
        send_byte(msp_pkg::SYSEX_START);
        repeat (n) send_byte(rand_data());
        send_byte(msp_pkg::SYSEX_END);
        gen_status = msp_pkg::SYSEX_START;
    endtask

    // One random chunk: mostly well-formed messages, some running status and noise
    task automatic send_random_message();
        int         pick;
        logic [7:0] s;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 27) begin
            send_sysex();
        end else if (pick < 45) begin
            // data only, under whatever status is running
            repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(0, 127)));
            if (gen_status == msp_pkg::SYSEX_START)
                send_byte(msp_pkg::SYSEX_END);
        end else begin
            s = 8'($urandom_range(128, 255));
            if (s == msp_pkg::SYSEX_START) begin
                send_sysex();
            end else begin
                send_byte(s);
                repeat (status_data_bytes(s)) send_byte(rand_data());
                gen_status = s;
            end
        end
    endtask

    task automatic wait_results_drained(output bit ok);
        int guard;
        guard = 0;
        while (expected_msgs.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        ok = (expected_msgs.size() == 0);
    endtask

    // Field extremes and every special case in sequence
    task automatic test_directed();
        logic [7:0] seq[$];
        seq = '{8'h00,                       // data with no status yet
                8'h90, 8'h3C, 8'h7F,         // note on
                8'h40, 8'h00,                // running status
                8'hE0, 8'hF7, 8'hFF,         // new status, then status bytes taken as data
                8'hC0, 8'h80,                // one-byte message, status as data
                8'hF8,                       // zero-length status
                8'h10,                       // data under zero-length status
                8'hF2, 8'h01, 8'h02,         // song position
                8'hF0, 8'h7F, 8'h80, msp_pkg::SYSEX_END,  // sysex with status inside
                8'h22, msp_pkg::SYSEX_END,   // data after sysex reopens it
                msp_pkg::SYSEX_START, msp_pkg::SYSEX_END,  // empty sysex
                msp_pkg::SYSEX_END};         // stray end outside sysex
        foreach (seq[i])
            send_byte(seq[i]);
        gen_status = msp_pkg::SYSEX_END;
    endtask

    task automatic test_random(input int n_bytes);
        int stop_at;
        stop_at = bytes_offered + n_bytes;
        while (bytes_offered < stop_at)
            send_random_message();
    endtask

    // Back-to-back traffic with both sides always ready
    task automatic test_no_idle(input int n_bytes);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random(n_bytes);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Long output hold-off while input keeps coming: block must fill and stall
    task automatic test_output_stall();
        stall_left = 300;
        repeat (30) begin
            send_byte(8'h90 | 8'($urandom_range(0, 15)));
            send_byte(8'($urandom_range(0, 127)));
            send_byte(8'($urandom_range(0, 127)));
        end
        gen_status = 8'h90;
    endtask

    // Sender stops until every owed message is out, then resumes
    task automatic test_sender_pause();
        bit ok;
        test_random(40);
        @(negedge i_clk);
        rx_if.valid <= 1'b0;
        wait_results_drained(ok);
        if (!ok)
            report_error("results did not drain during sender pause");
        test_random(40);
    endtask

    initial begin
        bit ok;
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        rx_if.valid        = 1'b0;
        rx_if.data.rx_byte = 8'h00;
        msg_if.ready       = 1'b0;
        parse_st           = '0;
        mismatch_count     = 0;
        bytes_offered      = 0;
        stall_left         = 0;
        tx_idle_on         = 1'b1;
        rx_idle_on         = 1'b1;
        gen_status         = 8'h00;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(700);
        test_output_stall();
        test_no_idle(300);
        test_sender_pause();
        test_random(500);

        @(negedge i_clk);
        rx_if.valid <= 1'b0;
        wait_results_drained(ok);
        repeat (10) @(posedge i_clk);
        if (!ok || expected_msgs.size() != 0)
            report_error($sformatf("%0d expected messages never arrived", expected_msgs.size()));

        if (mismatch_count == 0) begin
            $display("midi_stream_parser_top verification clean");
        end else begin
            $display("midi_stream_parser_top verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("midi_stream_parser_top verification failed");
        $finish;
    end

endmodule

FILE: files.f
design/msp_pkg.sv
design/msp_stream_if.sv
design/msp_step.sv
design/midi_stream_parser_top.sv
tb/sv/midi_stream_parser_top_tb.sv
